// File: sv/cbp_pkg.sv
`timescale 1ns / 1ps
// Package for the cubic Bezier point evaluator: widths, fixed-point
// constants and the control point bundle. Depends on nothing.
package cbp_pkg;

  // Fraction bits of the curve parameter t and of the Bernstein weights.
  localparam int ParamFracBits = 16;

  localparam int CoordW    = 32;
  localparam int ParamW    = ParamFracBits + 1;
  localparam int SqW       = 2 * ParamW;
  localparam int TripleW   = SqW + 2;
  localparam int ProdW     = ParamW + 1 + CoordW;
  localparam int SumW      = ProdW + 2;
  localparam int NumStages = 9;

  typedef logic        [ParamW-1:0] param_t;
  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t p0_x;
    coord_t p0_y;
    coord_t p1_x;
    coord_t p1_y;
    coord_t p2_x;
    coord_t p2_y;
    coord_t p3_x;
    coord_t p3_y;
  } ctrl_pts_t;

  localparam param_t ParamOne = {1'b1, {ParamFracBits{1'b0}}};

endpackage

// File: sv/cbp_in_if.sv
`timescale 1ns / 1ps
// Input channel of the cubic Bezier point evaluator: four control points
// and the curve parameter. Depends on cbp_pkg.
interface cbp_in_if;
  import cbp_pkg::*;

  logic                valid;
  logic                ready;
  logic signed [CoordW-1:0] p0_x;
  logic signed [CoordW-1:0] p0_y;
  logic signed [CoordW-1:0] p1_x;
  logic signed [CoordW-1:0] p1_y;
  logic signed [CoordW-1:0] p2_x;
  logic signed [CoordW-1:0] p2_y;
  logic signed [CoordW-1:0] p3_x;
  logic signed [CoordW-1:0] p3_y;
  logic [ParamW-1:0]   param_t;

  modport source (
    output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, param_t,
    input  ready
  );
  modport sink (
    input  valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, param_t,
    output ready
  );
endinterface

// File: sv/cbp_out_if.sv
`timescale 1ns / 1ps
// Output channel of the cubic Bezier point evaluator: one curve point.
// Depends on cbp_pkg.
interface cbp_out_if;
  import cbp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;

  modport source (
    output valid, point_x, point_y,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y,
    output ready
  );
endinterface

// File: sv/cubic_bezier_point_2d.sv
`timescale 1ns / 1ps
// Top level of the cubic Bezier point evaluator: a nine-stage pipeline.
// Depends on cbp_pkg, cbp_in_if and cbp_out_if.
//
//   Channel | Direction | Beat contents
//   --------+-----------+-------------------------------------------------
//   in_i    | sink      | p0..p3 x/y (signed Q16.16), param_t (Q1.16)
//   out_o   | source    | point_x, point_y (signed Q16.16, saturated)
//
// One beat is taken per cycle and one point leaves per cycle while out_o is
// ready; each beat passes through the nine register stages, each holding one
// item. Reset clears only the stage valid bits.
// A stall on out_o holds the last stage, and each earlier stage keeps moving
// until it runs into an occupied stage, so bubbles are squeezed out and no
// beat is lost or repeated. in_i.ready is low only when every stage is full.
module cubic_bezier_point_2d (
  input  logic   clk_i,
  input  logic   rst_ni,
  cbp_in_if.sink   in_i,
  cbp_out_if.source out_o
);
  import cbp_pkg::*;

  // Half of one weight LSB, used by every round-half-up step.
  localparam logic [SqW-1:0]     SqHalf     = SqW'(1) << (ParamFracBits - 1);
  localparam logic [TripleW-1:0] TripleHalf = TripleW'(1) << (ParamFracBits - 1);
  localparam logic [SumW-1:0]    SumHalf    = SumW'(1) << (ParamFracBits - 1);
  localparam logic signed [SumW-1:0] SatMax = SumW'({1'b0, {(CoordW-1){1'b1}}});
  localparam logic signed [SumW-1:0] SatMin = -SatMax - SumW'(1);

  // Per-stage valid bits and load enables. A stage loads when it is empty
  // or when the stage after it is loading too.
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] en;

  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || out_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 0: clamp t to 1.0 and form u = 1 - t.
  ctrl_pts_t pts_in;
  param_t    t_clamp;
  param_t    t0_q, u0_q;
  ctrl_pts_t pts0_q;

  assign pts_in  = '{p0_x: in_i.p0_x, p0_y: in_i.p0_y, p1_x: in_i.p1_x,
                     p1_y: in_i.p1_y, p2_x: in_i.p2_x, p2_y: in_i.p2_y,
                     p3_x: in_i.p3_x, p3_y: in_i.p3_y};
  assign t_clamp = (in_i.param_t > ParamOne) ? ParamOne : in_i.param_t;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      t0_q   <= t_clamp;
      u0_q   <= ParamOne - t_clamp;
      pts0_q <= pts_in;
    end
  end

  // Stage 1: raw squares u*u and t*t.
  logic [SqW-1:0] uu1_q, tt1_q;
  param_t         t1_q, u1_q;
  ctrl_pts_t      pts1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      uu1_q  <= u0_q * u0_q;
      tt1_q  <= t0_q * t0_q;
      t1_q   <= t0_q;
      u1_q   <= u0_q;
      pts1_q <= pts0_q;
    end
  end

  // Stage 2: round the squares back to the weight format.
  logic [SqW-1:0] uu_rnd, tt_rnd;
  param_t         usq2_q, tsq2_q, t2_q, u2_q;
  ctrl_pts_t      pts2_q;

  assign uu_rnd = (uu1_q + SqHalf) >> ParamFracBits;
  assign tt_rnd = (tt1_q + SqHalf) >> ParamFracBits;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      usq2_q <= uu_rnd[ParamW-1:0];
      tsq2_q <= tt_rnd[ParamW-1:0];
      t2_q   <= t1_q;
      u2_q   <= u1_q;
      pts2_q <= pts1_q;
    end
  end

  // Stage 3: raw cubic terms. The factor three of the middle weights is
  // applied in the next stage as a shift and add.
  logic [SqW-1:0] pa3_q, pb3_q, pc3_q, pd3_q;
  ctrl_pts_t      pts3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      pa3_q  <= usq2_q * u2_q;
      pb3_q  <= usq2_q * t2_q;
      pc3_q  <= u2_q * tsq2_q;
      pd3_q  <= tsq2_q * t2_q;
      pts3_q <= pts2_q;
    end
  end

  // Stage 4: round to the four Bernstein weights.
  logic [TripleW-1:0] pb_x3, pc_x3;
  logic [SqW-1:0]     wa_rnd, wd_rnd;
  logic [TripleW-1:0] wb_rnd, wc_rnd;
  param_t             wa4_q, wb4_q, wc4_q, wd4_q;
  ctrl_pts_t          pts4_q;

  assign pb_x3  = {2'b00, pb3_q} + {1'b0, pb3_q, 1'b0};
  assign pc_x3  = {2'b00, pc3_q} + {1'b0, pc3_q, 1'b0};
  assign wa_rnd = (pa3_q + SqHalf) >> ParamFracBits;
  assign wd_rnd = (pd3_q + SqHalf) >> ParamFracBits;
  assign wb_rnd = (pb_x3 + TripleHalf) >> ParamFracBits;
  assign wc_rnd = (pc_x3 + TripleHalf) >> ParamFracBits;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      wa4_q  <= wa_rnd[ParamW-1:0];
      wb4_q  <= wb_rnd[ParamW-1:0];
      wc4_q  <= wc_rnd[ParamW-1:0];
      wd4_q  <= wd_rnd[ParamW-1:0];
      pts4_q <= pts3_q;
    end
  end

  // Stage 5: eight weight-by-coordinate products, exact.
  logic signed [ProdW-1:0] px5_q [4];
  logic signed [ProdW-1:0] py5_q [4];

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      px5_q[0] <= $signed({1'b0, wa4_q}) * pts4_q.p0_x;
      px5_q[1] <= $signed({1'b0, wb4_q}) * pts4_q.p1_x;
      px5_q[2] <= $signed({1'b0, wc4_q}) * pts4_q.p2_x;
      px5_q[3] <= $signed({1'b0, wd4_q}) * pts4_q.p3_x;
      py5_q[0] <= $signed({1'b0, wa4_q}) * pts4_q.p0_y;
      py5_q[1] <= $signed({1'b0, wb4_q}) * pts4_q.p1_y;
      py5_q[2] <= $signed({1'b0, wc4_q}) * pts4_q.p2_y;
      py5_q[3] <= $signed({1'b0, wd4_q}) * pts4_q.p3_y;
    end
  end

  // Stage 6: pairwise sums.
  logic signed [SumW-1:0] sx01_6_q, sx23_6_q, sy01_6_q, sy23_6_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      sx01_6_q <= SumW'(px5_q[0]) + SumW'(px5_q[1]);
      sx23_6_q <= SumW'(px5_q[2]) + SumW'(px5_q[3]);
      sy01_6_q <= SumW'(py5_q[0]) + SumW'(py5_q[1]);
      sy23_6_q <= SumW'(py5_q[2]) + SumW'(py5_q[3]);
    end
  end

  // Stage 7: full weighted sums.
  logic signed [SumW-1:0] sx7_q, sy7_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      sx7_q <= sx01_6_q + sx23_6_q;
      sy7_q <= sy01_6_q + sy23_6_q;
    end
  end

  // Stage 8: round half up (floor after adding half), then saturate to the
  // 32-bit coordinate range. This is the output register.
  logic signed [SumW-1:0] rx, ry;
  coord_t                 sat_x, sat_y;
  coord_t                 px8_q, py8_q;

  assign rx = (sx7_q + $signed(SumHalf)) >>> ParamFracBits;
  assign ry = (sy7_q + $signed(SumHalf)) >>> ParamFracBits;

  always_comb begin
    if (rx > SatMax) begin
      sat_x = SatMax[CoordW-1:0];
    end else if (rx < SatMin) begin
      sat_x = SatMin[CoordW-1:0];
    end else begin
      sat_x = rx[CoordW-1:0];
    end
    if (ry > SatMax) begin
      sat_y = SatMax[CoordW-1:0];
    end else if (ry < SatMin) begin
      sat_y = SatMin[CoordW-1:0];
    end else begin
      sat_y = ry[CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      px8_q <= sat_x;
      py8_q <= sat_y;
    end
  end

  assign out_o.valid   = vld_q[NumStages-1];
  assign out_o.point_x = px8_q;
  assign out_o.point_y = py8_q;

endmodule
